FILE: design/ped_pkg.sv
`timescale 1ns / 1ps
package ped_pkg;

  localparam int LEN_WIDTH = 16;
  localparam int QDEPTH    = 4;
  localparam int QA_W      = $clog2(QDEPTH);
  localparam int QC_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_F_UP = 8'h46;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  ch;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]           n;
    res_t                 r0;
    res_t                 r1;
    phase_t               ph;
    logic [7:0]           held;
    logic [LEN_WIDTH-1:0] cnt;
  } dec_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A_UP) && (c <= CH_F_UP));
  endfunction

  // 'A'..'F' have low nibbles 1..6
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= CH_9) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

  function automatic logic [LEN_WIDTH-1:0] sat_inc(input logic [LEN_WIDTH-1:0] c);
    return (&c) ? c : LEN_WIDTH'(c + 1'b1);
  endfunction

  function automatic logic [15:0] len16(input logic [LEN_WIDTH-1:0] c);
    logic [LEN_WIDTH+15:0] ext;
    ext = {16'b0, c};
    return ext[15:0];
  endfunction

endpackage

FILE: design/ped_decode.sv
`timescale 1ns / 1ps
module ped_decode import ped_pkg::*; (
  input  phase_t               ph,
  input  logic [7:0]           held,
  input  logic [LEN_WIDTH-1:0] cnt,
  input  logic [7:0]           c,
  output dec_t                 dec
);

  logic [LEN_WIDTH-1:0] cnt1;
  logic [LEN_WIDTH-1:0] cnt2;
  logic                 hex_c;

  assign cnt1  = sat_inc(cnt);
  assign cnt2  = sat_inc(cnt1);
  assign hex_c = is_hex(c);

  always_comb begin
    dec      = '0;
    dec.ph   = PH_IDLE;
    dec.held = held;
    dec.cnt  = cnt;
    if (c == CH_NUL) begin
      dec.held = '0;
      dec.cnt  = '0;
      if (ph == PH_DIGIT) begin
        dec.n  = 2'd2;
        dec.r0 = '{len: len16(cnt1), ch: held, last: 1'b0};
        dec.r1 = '{len: len16(cnt1), ch: CH_NUL, last: 1'b1};
      end else begin
        dec.n  = 2'd1;
        dec.r0 = '{len: len16(cnt), ch: CH_NUL, last: 1'b1};
      end
    end else begin
      unique case (ph)
        PH_PCT: begin
          if (hex_c) begin
            dec.held = c;
            dec.ph   = PH_DIGIT;
          end else if (c == CH_PCT) begin
            dec.ph = PH_PCT;
          end else begin
            dec.n   = 2'd1;
            dec.cnt = cnt1;
            dec.r0  = '{len: len16(cnt1), ch: c, last: 1'b0};
          end
        end
        PH_DIGIT: begin
          dec.held = '0;
          dec.n    = 2'd1;
          dec.cnt  = cnt1;
          if (hex_c) begin
            dec.r0 = '{len: len16(cnt1), ch: {hex_val(held), hex_val(c)}, last: 1'b0};
          end else begin
            dec.r0 = '{len: len16(cnt1), ch: held, last: 1'b0};
            if (c == CH_PCT) begin
              dec.ph = PH_PCT;
            end else begin
              dec.n   = 2'd2;
              dec.cnt = cnt2;
              dec.r1  = '{len: len16(cnt2), ch: c, last: 1'b0};
            end
          end
        end
        default: begin
          if (c == CH_PCT) begin
            dec.ph = PH_PCT;
          end else begin
            dec.n   = 2'd1;
            dec.cnt = cnt1;
            dec.r0  = '{len: len16(cnt1), ch: c, last: 1'b0};
          end
        end
      endcase
    end
  end

endmodule

FILE: design/percent_escape_decoder.sv
`timescale 1ns / 1ps
// Percent-escape decoder for a byte stream.
// Input: one string byte per word on in_tdata; a zero byte ends the string.
// Output: decoded bytes on out_tdata with the running decoded length;
// out_tlast marks the end word after the terminator, which carries the
// final length and a zero byte. The length counter saturates.
// Each result is registered in a result queue before it reaches the output.
// Throughput: one byte per cycle. A byte can cause two words (held digit
// plus the byte, or held digit plus end word); the extra word drains from
// a 4-entry result queue, and in_tready drops while fewer than two queue
// slots are free.
// Reset: escape state, held digit and length clear, the queue empties.
// A stalled receiver holds out_tdata/out_tlast steady; input bytes are
// still taken while at least two queue slots stay free.
module percent_escape_decoder import ped_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_char, [23:8] decoded_len
  output logic        out_tlast   // is_end
);

  phase_t               phase_r, phase_nxt;
  logic [7:0]           held_r, held_nxt;
  logic [LEN_WIDTH-1:0] len_r, len_nxt;

  res_t                 q_r [QDEPTH];
  logic [QA_W-1:0]      wp_r, wp_nxt;
  logic [QA_W-1:0]      rp_r, rp_nxt;
  logic [QC_W-1:0]      q_cnt_r, q_cnt_nxt;

  dec_t                 dec;
  logic                 in_acc;
  logic                 out_acc;
  logic [1:0]           push_n;
  res_t                 head;

  ped_decode u_dec (
    .ph   (phase_r),
    .held (held_r),
    .cnt  (len_r),
    .c    (in_tdata),
    .dec  (dec)
  );

  assign in_tready  = (q_cnt_r <= QC_W'(QDEPTH - 2));
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (q_cnt_r != '0);
  assign out_acc    = out_tvalid && out_tready;
  assign push_n     = in_acc ? dec.n : 2'd0;

  assign head       = q_r[rp_r];
  assign out_tdata  = {head.len, head.ch};
  assign out_tlast  = head.last;

  always_comb begin
    phase_nxt = in_acc ? dec.ph   : phase_r;
    held_nxt  = in_acc ? dec.held : held_r;
    len_nxt   = in_acc ? dec.cnt  : len_r;
    wp_nxt    = QA_W'(wp_r + push_n);
    rp_nxt    = out_acc ? QA_W'(rp_r + 1'b1) : rp_r;
    q_cnt_nxt = QC_W'(q_cnt_r + push_n - {1'b0, out_acc});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
      len_r   <= '0;
      wp_r    <= '0;
      rp_r    <= '0;
      q_cnt_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      len_r   <= len_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wp_r] <= dec.r0;
    end
    if (push_n == 2'd2) begin
      q_r[QA_W'(wp_r + 1'b1)] <= dec.r1;
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QC_W'(QDEPTH))
    else $error("result queue overflow");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tdata == CH_NUL)) |=> (phase_r == PH_IDLE) && (len_r == '0))
    else $error("terminator did not clear string state");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[7:0] == CH_NUL))
    else $error("end word carries a nonzero byte");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench import ped_pkg::*; ();

  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] len;
    logic        last;
  } dec_word_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] in_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;           // [7:0] out_char, [23:8] decoded_len
  logic        out_tlast;           // is_end

  bit no_gaps = 1'b0;
  int mismatch_count = 0;

  dec_word_t            expected_words[$];
  phase_t               dec_phase = PH_IDLE;
  logic [7:0]           dec_held  = 8'h00;
  logic [LEN_WIDTH-1:0] dec_count = '0;

  percent_escape_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_A_UP && c <= CH_F_UP);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c <= CH_9) return 4'(c - CH_0);
    return 4'(c - CH_A_UP + 8'd10);
  endfunction

  function void push_word(input logic [7:0] ch, input logic last);
    if (!last && dec_count != {LEN_WIDTH{1'b1}}) dec_count = dec_count + 1'b1;
    expected_words.push_back('{ch, 16'(dec_count), last});
  endfunction

  function void plain_byte(input logic [7:0] c);
    if (c == CH_PCT) begin
      dec_phase = PH_PCT;
    end else begin
      dec_phase = PH_IDLE;
      push_word(c, 1'b0);
    end
  endfunction

  function void decode_byte(input logic [7:0] c);
    if (c == CH_NUL) begin
      if (dec_phase == PH_DIGIT) push_word(dec_held, 1'b0);
      push_word(8'h00, 1'b1);
      dec_phase = PH_IDLE;
      dec_held  = 8'h00;
      dec_count = '0;
    end else begin
      case (dec_phase)
        PH_PCT: begin
          if (hex_digit(c)) begin
            dec_held  = c;
            dec_phase = PH_DIGIT;
          end else begin
            plain_byte(c);
          end
        end
        PH_DIGIT: begin
          if (hex_digit(c)) begin
            push_word({nibble_of(dec_held), nibble_of(c)}, 1'b0);
            dec_phase = PH_IDLE;
          end else begin
            push_word(dec_held, 1'b0);
            plain_byte(c);
          end
          dec_held = 8'h00;
        end
        default: plain_byte(c);
      endcase
    end
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    return (v < 10) ? 8'(CH_0 + v) : 8'(CH_A_UP + v - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (hex_digit(c));
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // word check and receiver stalls
  always @(posedge clk) begin
    dec_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, {7'h0, out_tlast, out_tdata});
      end else begin
        want = expected_words.pop_front();
        if (out_tdata[7:0] !== want.ch) report_mismatch("out_char", want.ch, out_tdata[7:0]);
        if (out_tdata[23:8] !== want.len)
          report_mismatch("decoded_len", want.len, out_tdata[23:8]);
        if (out_tlast !== want.last) report_mismatch("is_end", want.last, out_tlast);
      end
    end
    out_tready <= no_gaps || ($urandom_range(99) >= 37);
  end

  task automatic send_byte(input logic [7:0] c);
    while (!no_gaps && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    send_byte(8'h01);
    send_byte(8'hFF);
    send_text("%00%FF");
    send_byte(CH_NUL);
    send_text("%9A%a%G%4/");
    send_byte(CH_NUL);
    send_text("%%41%");        // doubled percent, then lone percent at end
    send_byte(CH_NUL);
    send_text("%7");           // held digit flushed by terminator
    send_byte(CH_NUL);
    send_byte(CH_NUL);         // empty string
  endtask

  task automatic test_random(input int target);
    logic [7:0] text[$];
    int n;
    int pick;
    int sent;
    sent = 0;
    while (sent < target) begin
      text = {};
      n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          text.push_back(CH_PCT);
          text.push_back(hex_char());
          text.push_back(hex_char());
        end else if (pick < 50) begin
          text.push_back(CH_PCT);
          if ($urandom_range(1)) text.push_back(hex_char());
          text.push_back(non_hex_char());
        end else if (pick < 54) begin
          text.push_back(CH_PCT);
        end else begin
          text.push_back(8'($urandom_range(0, 255)));
        end
      end
      pick = $urandom_range(5);
      if (pick == 0) begin
        text.push_back(CH_PCT);
      end else if (pick == 1) begin
        text.push_back(CH_PCT);
        text.push_back(hex_char());
      end
      text.push_back(CH_NUL);
      foreach (text[i]) send_byte(text[i]);
      sent += text.size();
    end
  endtask

  // burst with no idling on either side
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    test_random(300);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_back_to_back();
    test_random(800);
    drain_results();
    test_random(700);
    drain_results();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
